// File: rtl/mfea_pkg.sv
`timescale 1ns / 1ps
package mfea_pkg;

  // Default pass length limit.
  localparam int unsigned MAX_FACES_DEF = 65536;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned OPND_W   = 33;
  localparam int unsigned PROD_W   = 66;
  localparam int unsigned ENERGY_W = 48;
  localparam int unsigned SUM_W    = 63;
  localparam int unsigned FCNT_W   = 17;
  localparam int unsigned FLOOR_W  = 16;
  localparam int unsigned DIV_W    = 64;

  localparam int unsigned IN_DATA_W  = 352;
  localparam int unsigned OUT_DATA_W = 120;

  // Configuration register indexes.
  typedef enum logic {
    REG_FACE_COUNT = 1'b0,
    REG_DET_FLOOR  = 1'b1
  } reg_idx_t;

  // Micro-operation steps of the shared multiplier.
  typedef enum logic [3:0] {
    ST_J00_A  = 4'd0,
    ST_J00_B  = 4'd1,
    ST_J01_A  = 4'd2,
    ST_J01_B  = 4'd3,
    ST_J10_A  = 4'd4,
    ST_J10_B  = 4'd5,
    ST_J11_A  = 4'd6,
    ST_J11_B  = 4'd7,
    ST_DET_A  = 4'd8,
    ST_DET_B  = 4'd9,
    ST_SQ00   = 4'd10,
    ST_SQ01   = 4'd11,
    ST_SQ10   = 4'd12,
    ST_SQ11   = 4'd13,
    ST_WGT_LO = 4'd14,
    ST_WGT_HI = 4'd15
  } step_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// File: rtl/mips_face_energy_accumulator.sv
`timescale 1ns / 1ps
// Sequence: an invalid face goes straight to the output; a flipped face stops after the
// Jacobian and determinant products; a regular face also runs the squares, the divider and
// the area weighting, on the one shared 33x33 multiplier and the bit-serial 48-step divider.
// Throughput: one face at a time; in_tready is high only while the sequencer idles.
// Reset (rst_n, synchronous, active low): face_count 1, det_floor 0, totals cleared.
module mips_face_energy_accumulator #(
  parameter int unsigned MAX_FACES = mfea_pkg::MAX_FACES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // u_first, v_first, u_second, v_second, u_third, v_third, inv_row0_col0,
  // inv_row0_col1, inv_row1_col0, inv_row1_col1, face_area
  input  logic [mfea_pkg::IN_DATA_W-1:0]      in_tdata,
  // face_ok
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // weighted_energy, face_flipped, running_total, any_flipped, zero padding
  output logic [mfea_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [mfea_pkg::FCNT_W-1:0]         cfg_data
);
  import mfea_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FACES + 1);
  localparam int unsigned CMP_W = ((CNT_W > FCNT_W) ? CNT_W : FCNT_W) + 1;
  localparam int unsigned WACC_W = ENERGY_W + COORD_W;
  localparam logic signed [50:0] JLIM = 51'sd2147483647;

  // Configuration and accumulated pass state.
  logic [FCNT_W-1:0]  face_count_r;
  logic [FLOOR_W-1:0] det_floor_r;
  logic [SUM_W-1:0]   energy_sum_r;
  logic               flip_seen_r;
  logic [CNT_W-1:0]   faces_seen_r;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  // Face operands and intermediate results.
  logic signed [COORD_W-1:0] d00_r, d01_r, d10_r, d11_r;
  logic signed [COORD_W-1:0] m00_r, m01_r, m10_r, m11_r;
  logic [COORD_W-1:0]        area_r;
  logic signed [COORD_W-1:0] j_r [4];
  logic signed [50:0]        jacc_r;
  logic signed [63:0]        dacc_r;
  logic [DIV_W-1:0]          det_r, f2_r;
  logic [ENERGY_W-1:0]       e_r, wen_r;
  logic [WACC_W-1:0]         wacc_r;
  logic                      flip_r;

  logic signed [OPND_W-1:0]  opa, opb;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      div_start, div_done;
  logic [ENERGY_W-1:0]       div_quo;
  logic [DIV_W-1:0]          f2_sum;

  logic signed [50:0]        jsum;
  logic signed [64:0]        det_full;
  logic [WACC_W-1:0]         wacc_sum;
  logic                      in_fire, out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;

  // Saturated vertex differences.
  function automatic logic signed [COORD_W-1:0] sat_diff(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y
  );
    logic signed [COORD_W:0] d;
    d = {x[COORD_W-1], x} - {y[COORD_W-1], y};
    if (d[COORD_W] != d[COORD_W-1]) begin
      sat_diff = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_diff = d[COORD_W-1:0];
    end
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (step_r)
      ST_J00_A:  begin opa = {d00_r[31], d00_r}; opb = {m00_r[31], m00_r}; end
      ST_J00_B:  begin opa = {d01_r[31], d01_r}; opb = {m10_r[31], m10_r}; end
      ST_J01_A:  begin opa = {d00_r[31], d00_r}; opb = {m01_r[31], m01_r}; end
      ST_J01_B:  begin opa = {d01_r[31], d01_r}; opb = {m11_r[31], m11_r}; end
      ST_J10_A:  begin opa = {d10_r[31], d10_r}; opb = {m00_r[31], m00_r}; end
      ST_J10_B:  begin opa = {d11_r[31], d11_r}; opb = {m10_r[31], m10_r}; end
      ST_J11_A:  begin opa = {d10_r[31], d10_r}; opb = {m01_r[31], m01_r}; end
      ST_J11_B:  begin opa = {d11_r[31], d11_r}; opb = {m11_r[31], m11_r}; end
      ST_DET_A:  begin opa = {j_r[0][31], j_r[0]}; opb = {j_r[3][31], j_r[3]}; end
      ST_DET_B:  begin opa = {j_r[1][31], j_r[1]}; opb = {j_r[2][31], j_r[2]}; end
      ST_SQ00:   begin opa = {j_r[0][31], j_r[0]}; opb = {j_r[0][31], j_r[0]}; end
      ST_SQ01:   begin opa = {j_r[1][31], j_r[1]}; opb = {j_r[1][31], j_r[1]}; end
      ST_SQ10:   begin opa = {j_r[2][31], j_r[2]}; opb = {j_r[2][31], j_r[2]}; end
      ST_SQ11:   begin opa = {j_r[3][31], j_r[3]}; opb = {j_r[3][31], j_r[3]}; end
      ST_WGT_LO: begin opa = {1'b0, e_r[31:0]}; opb = {1'b0, area_r}; end
      ST_WGT_HI: begin opa = {17'b0, e_r[47:32]}; opb = {1'b0, area_r}; end
      default:   begin opa = '0; opb = '0; end
    endcase
  end

  mfea_mul u_mul (
    .clk    (clk),
    .opa    (opa),
    .opb    (opb),
    .prod_r (prod_r)
  );

  // Accumulator datapath fed by the product register.
  assign jsum     = jacc_r + 51'(prod_r >>> 16);
  assign det_full = {dacc_r[63], dacc_r} - 65'(prod_r);
  assign f2_sum   = f2_r + prod_r[DIV_W-1:0];
  assign wacc_sum = wacc_r + {prod_r[ENERGY_W-1:0], 32'b0};
  assign div_start = (state_r == S_ACC) && (step_r == ST_SQ11);

  mfea_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (f2_sum),
    .den    (det_r),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          step_nxt  = ST_J00_A;
          state_nxt = in_tuser ? S_MUL : S_OUT;
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        priority if (step_r == ST_DET_B && det_full <= $signed({49'b0, det_floor_r})) begin
          state_nxt = S_OUT;
        end else if (step_r == ST_SQ11) begin
          state_nxt = S_DIV;
        end else if (step_r == ST_WGT_HI) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt  = step_t'(step_r + 4'd1);
          state_nxt = S_MUL;
        end
      end
      S_DIV: begin
        if (div_done) begin
          step_nxt  = ST_WGT_LO;
          state_nxt = S_MUL;
        end
      end
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      d00_r  <= sat_diff(in_tdata[95:64],  in_tdata[31:0]);
      d10_r  <= sat_diff(in_tdata[127:96], in_tdata[63:32]);
      d01_r  <= sat_diff(in_tdata[159:128], in_tdata[31:0]);
      d11_r  <= sat_diff(in_tdata[191:160], in_tdata[63:32]);
      m00_r  <= in_tdata[223:192];
      m01_r  <= in_tdata[255:224];
      m10_r  <= in_tdata[287:256];
      m11_r  <= in_tdata[319:288];
      area_r <= in_tdata[351:320];
      wen_r  <= '0;
      flip_r <= 1'b0;
    end
    if (state_r == S_ACC) begin
      unique case (step_r)
        ST_J00_A, ST_J01_A, ST_J10_A, ST_J11_A: jacc_r <= 51'(prod_r >>> 16);
        ST_J00_B, ST_J01_B, ST_J10_B, ST_J11_B: begin
          if (jsum > JLIM) begin
            j_r[step_r[2:1]] <= 32'sh7FFF_FFFF;
          end else if (jsum < -JLIM) begin
            j_r[step_r[2:1]] <= -32'sh7FFF_FFFF;
          end else begin
            j_r[step_r[2:1]] <= jsum[31:0];
          end
        end
        ST_DET_A: dacc_r <= prod_r[63:0];
        ST_DET_B: begin
          det_r <= det_full[63:0];
          if (det_full <= $signed({49'b0, det_floor_r})) begin
            flip_r <= 1'b1;
            wen_r  <= '1;
          end
        end
        ST_SQ00:  f2_r <= prod_r[63:0];
        ST_SQ01, ST_SQ10, ST_SQ11: f2_r <= f2_sum;
        ST_WGT_LO: wacc_r <= WACC_W'(prod_r[63:0]);
        ST_WGT_HI: begin
          if (wacc_sum[WACC_W-1:ENERGY_W+16] != '0) begin
            wen_r <= '1;
          end else begin
            wen_r <= wacc_sum[ENERGY_W+15:16];
          end
        end
        default: jacc_r <= jacc_r;
      endcase
    end
    if (state_r == S_DIV && div_done) begin
      e_r <= div_quo;
    end
  end

  // Pass bookkeeping at result hand-off.
  logic [CMP_W-1:0] count_eff, seen_plus;
  logic             pass_end;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic             out_load;

  always_comb begin
    if (face_count_r == '0) begin
      count_eff = CMP_W'(1);
    end else if (CMP_W'(face_count_r) > CMP_W'(MAX_FACES)) begin
      count_eff = CMP_W'(MAX_FACES);
    end else begin
      count_eff = CMP_W'(face_count_r);
    end
    seen_plus = CMP_W'(faces_seen_r) + CMP_W'(1);
    pass_end  = seen_plus >= count_eff;
    sum_ext   = {1'b0, energy_sum_r} + (SUM_W+1)'(wen_r);
    sum_sat   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  end

  assign out_load = (state_r == S_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata <= {7'b0, flip_seen_r | flip_r, sum_sat, flip_r, wen_r};
      out_tlast <= pass_end;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= ST_J00_A;
      out_tvalid   <= 1'b0;
      face_count_r <= FCNT_W'(1);
      det_floor_r  <= '0;
      energy_sum_r <= '0;
      flip_seen_r  <= 1'b0;
      faces_seen_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FACE_COUNT: face_count_r <= cfg_data;
          REG_DET_FLOOR:  det_floor_r  <= cfg_data[FLOOR_W-1:0];
          default:        det_floor_r  <= det_floor_r;
        endcase
      end
      if (out_load) begin
        if (pass_end) begin
          energy_sum_r <= '0;
          flip_seen_r  <= 1'b0;
          faces_seen_r <= '0;
        end else begin
          energy_sum_r <= sum_sat;
          flip_seen_r  <= flip_seen_r | flip_r;
          faces_seen_r <= seen_plus[CNT_W-1:0];
        end
      end
    end
  end

  // A flipped face always reports the saturated energy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[ENERGY_W]) |-> (out_tdata[ENERGY_W-1:0] == '1))
    else $error("flipped face without saturated energy");
  // A flipped face is always reflected in the pass flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[ENERGY_W]) |-> out_tdata[ENERGY_W+SUM_W+1])
    else $error("any_flipped missing a flipped face");
  // The face counter stays inside the pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(faces_seen_r) < CMP_W'(MAX_FACES))
    else $error("face counter beyond pass limit");
  // The divider is only waited on after it was started.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == S_DIV))
    else $error("divider started outside the sequence");

endmodule

// File: rtl/mfea_mul.sv
`timescale 1ns / 1ps
module mfea_mul (
  input  logic                                  clk,
  input  logic signed [mfea_pkg::OPND_W-1:0]    opa,
  input  logic signed [mfea_pkg::OPND_W-1:0]    opb,
  output logic signed [mfea_pkg::PROD_W-1:0]    prod_r
);
  import mfea_pkg::*;

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

endmodule

// File: rtl/mfea_div.sv
`timescale 1ns / 1ps
module mfea_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mfea_pkg::DIV_W-1:0]        num,
  input  logic [mfea_pkg::DIV_W-1:0]        den,
  output logic                              done_r,
  output logic [mfea_pkg::ENERGY_W-1:0]     quo_r
);
  import mfea_pkg::*;

  localparam int unsigned LOW_W = DIV_W / 2;
  localparam int unsigned CNT_W = $clog2(ENERGY_W + 1);

  logic                busy_r, busy_nxt;
  logic                done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIV_W-1:0]    rem_r, rem_nxt, den_r, den_nxt;
  logic [ENERGY_W-1:0] sh_r, sh_nxt, quo_nxt;
  logic [DIV_W-1:0]    trial;
  logic [DIV_W:0]      diff;

  // One quotient bit per cycle, restoring, over the numerator scaled by 2^16.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh_nxt   = sh_r;
    quo_nxt  = quo_r;
    trial    = {rem_r[DIV_W-2:0], sh_r[ENERGY_W-1]};
    diff     = {1'b0, trial} - {1'b0, den_r};
    if (start) begin
      den_nxt = den;
      // A quotient of 2^48 or more saturates at once.
      if ({{LOW_W{1'b0}}, num[DIV_W-1:LOW_W]} >= den) begin
        quo_nxt  = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = {{LOW_W{1'b0}}, num[DIV_W-1:LOW_W]};
        sh_nxt   = {num[LOW_W-1:0], {(ENERGY_W-LOW_W){1'b0}}};
        cnt_nxt  = CNT_W'(ENERGY_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      sh_nxt = {sh_r[ENERGY_W-2:0], 1'b0};
      if (!diff[DIV_W]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[ENERGY_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[ENERGY_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    sh_r  <= sh_nxt;
    quo_r <= quo_nxt;
  end

  // A start never arrives while a division runs.
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> !start)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

// File: bench/mips_face_energy_accumulator_tb.sv
`timescale 1ns / 1ps
module mips_face_energy_accumulator_tb;
  import mfea_pkg::*;

  localparam logic [47:0] ENERGY_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] TOTAL_MAX = {63{1'b1}};
  localparam int RANDOM_FACES = 950;
  localparam int IDLE_LIMIT = 20000;

  // One face as it travels on the input channel.
  typedef struct packed {
    logic [31:0] area;
    logic [31:0] m11, m10, m01, m00;
    logic [31:0] v2, u2, v1, u1, v0, u0;
  } face_t;

  // One per-face result as it travels on the output channel.
  typedef struct {
    logic [47:0] energy;
    logic flipped;
    logic [62:0] total;
    logic any_flip;
    logic last;
  } face_result_t;

  // Directed stimulus row; has_exp marks rows with a typed-in result.
  typedef struct {
    face_t f;
    logic ok;
    logic has_exp;
    logic [47:0] exp_energy;
    logic exp_flip;
  } face_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we;
  logic cfg_index;
  logic [FCNT_W-1:0] cfg_data;

  mips_face_energy_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state and configuration copies.
  int unsigned pass_len_reg;
  int unsigned floor_reg;
  logic [62:0] pass_sum;
  logic pass_flip;
  int unsigned pass_faces;

  face_result_t pending_results[$];
  face_result_t last_pred;
  int errors, mismatches, faces_sent, results_seen, flips_seen, passes_seen;
  int idle_cycles;
  bit hold_long;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint floor_q16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint jac_entry(longint a, longint b, longint c, longint d);
    longint s;
    s = floor_q16(a * b) + floor_q16(c * d);
    if (s > 64'sd2147483647) return 64'sd2147483647;
    if (s < -64'sd2147483647) return -64'sd2147483647;
    return s;
  endfunction

  // Compute one face's energy, update pass totals, and return the result.
  function automatic face_result_t face_energy_predict(face_t f, logic ok);
    face_result_t r;
    longint d00, d10, d01, d11, j00, j01, j10, j11, det;
    logic [63:0] frob, q, rem, wgt;
    logic [127:0] prod;
    logic [64:0] r2;
    logic [15:0] frac;
    logic [48:0] sum48;
    logic [63:0] sum64;
    int unsigned cnt;
    r.energy = '0;
    r.flipped = 1'b0;
    if (ok) begin
      d00 = sat32(longint'($signed(f.u1)) - longint'($signed(f.u0)));
      d10 = sat32(longint'($signed(f.v1)) - longint'($signed(f.v0)));
      d01 = sat32(longint'($signed(f.u2)) - longint'($signed(f.u0)));
      d11 = sat32(longint'($signed(f.v2)) - longint'($signed(f.v0)));
      j00 = jac_entry(d00, $signed(f.m00), d01, $signed(f.m10));
      j01 = jac_entry(d00, $signed(f.m01), d01, $signed(f.m11));
      j10 = jac_entry(d10, $signed(f.m00), d11, $signed(f.m10));
      j11 = jac_entry(d10, $signed(f.m01), d11, $signed(f.m11));
      det = j00 * j11 - j01 * j10;
      if (det <= longint'(floor_reg)) begin
        r.flipped = 1'b1;
        r.energy = ENERGY_MAX;
      end else begin
        frob = 64'(j00 * j00) + 64'(j01 * j01) + 64'(j10 * j10) + 64'(j11 * j11);
        q = frob / 64'(det);
        rem = frob % 64'(det);
        if (q > 64'hFFFF_FFFF) begin
          wgt = {16'd0, ENERGY_MAX};
        end else begin
          r2 = {1'b0, rem};
          for (int i = 0; i < 16; i++) begin
            r2 = r2 << 1;
            frac = {frac[14:0], 1'b0};
            if (r2 >= 65'(det)) begin
              r2 = r2 - 65'(det);
              frac[0] = 1'b1;
            end
          end
          wgt = {q[47:0], 16'd0} | 64'(frac);
        end
        // Area weighting split into integer and fractional halves.
        prod = 128'(wgt) * 128'(f.area[31:16]);
        if (prod > 128'(ENERGY_MAX)) begin
          r.energy = ENERGY_MAX;
        end else begin
          sum64 = prod[63:0] + ((wgt * 64'(f.area[15:0])) >> 16);
          r.energy = (sum64 > 64'(ENERGY_MAX)) ? ENERGY_MAX : sum64[47:0];
        end
      end
    end
    sum64 = 64'(pass_sum) + 64'(r.energy);
    pass_sum = (sum64 > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum64[62:0];
    if (r.flipped) pass_flip = 1'b1;
    cnt = pass_len_reg;
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_FACES_DEF) cnt = MAX_FACES_DEF;
    r.last = (pass_faces + 1 >= cnt);
    r.total = pass_sum;
    r.any_flip = pass_flip;
    if (r.last) begin
      pass_sum = '0;
      pass_flip = 1'b0;
      pass_faces = 0;
    end else begin
      pass_faces++;
    end
    return r;
  endfunction

  // Write one register while the block idles.
  task automatic write_reg(reg_idx_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[FCNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FACE_COUNT) pass_len_reg = val & 32'h1FFFF;
    else floor_reg = val & 32'hFFFF;
  endtask

  // Offer one face and wait for its transaction; predict at acceptance.
  task automatic send_face(face_t f, logic ok);
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'(f);
    in_tuser <= ok;
    do @(posedge clk); while (!in_tready);
    last_pred = face_energy_predict(f, ok);
    pending_results.push_back(last_pred);
    faces_sent++;
    // Bursts: usually keep valid high, sometimes insert a gap.
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'($urandom_range(0, 2 << 16));
    endcase
  endfunction

  // Usually a well-formed face: positive-orientation vertices and a sane inverse; else random words.
  function automatic face_t rand_face();
    face_t f;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      f = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      f.u0 = rand_word(1); f.v0 = rand_word(1);
      f.u1 = f.u0 + rand_word(2); f.v1 = f.v0 + rand_word(1) / 8;
      f.u2 = f.u0 + rand_word(1) / 8; f.v2 = f.v0 + rand_word(2);
      f.m00 = rand_word(2); f.m11 = rand_word(2);
      f.m01 = rand_word(1) / 16; f.m10 = rand_word(1) / 16;
      f.area = (mode == 1) ? $urandom() : $urandom_range(0, 4 << 16);
    end
    return f;
  endfunction

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_long = 1'b0;
      end
      out_tready <= ($urandom_range(0, 3) != 0) || (($urandom() & 32'h100) != 0);
      @(posedge clk);
    end
  end

  // Result checking at each accepted transaction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      face_result_t want;
      logic [47:0] got_e;
      logic got_f, got_a;
      logic [62:0] got_t;
      got_e = out_tdata[47:0];
      got_f = out_tdata[48];
      got_t = out_tdata[111:49];
      got_a = out_tdata[112];
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("ERROR: unexpected result transaction at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        if (got_f) flips_seen++;
        if (out_tlast) passes_seen++;
        if (got_e !== want.energy || got_f !== want.flipped || got_t !== want.total ||
            got_a !== want.any_flip || out_tlast !== want.last) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("MISMATCH: exp e=%h f=%b t=%h a=%b l=%b got e=%h f=%b t=%h a=%b l=%b",
                     want.energy, want.flipped, want.total, want.any_flip, want.last,
                     got_e, got_f, got_t, got_a, out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("mips_face_energy_accumulator_tb: done, errors");
      $finish;
    end
  end

  face_row_t rows[$];

  task automatic add_row(face_t f, logic ok, logic has_exp, logic [47:0] e, logic fl);
    face_row_t r;
    r.f = f; r.ok = ok; r.has_exp = has_exp; r.exp_energy = e; r.exp_flip = fl;
    rows.push_back(r);
  endtask

  initial begin
    face_t f, ident;
    face_result_t p;
    int unsigned lens[4];
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_FACE_COUNT; cfg_data = '0;
    hold_long = 1'b0;
    errors = 0; mismatches = 0; faces_sent = 0; results_seen = 0;
    flips_seen = 0; passes_seen = 0;
    pass_len_reg = 1; floor_reg = 0; pass_sum = '0; pass_flip = 1'b0; pass_faces = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: invalid, flipped, degenerate, extremes and an identity face.
    ident = '{area: 32'h0001_0000, m11: 32'h0001_0000, m10: 0, m01: 0, m00: 32'h0001_0000,
              v2: 32'h0001_0000, u2: 0, v1: 0, u1: 32'h0001_0000, v0: 0, u0: 0};
    add_row(ident, 1'b0, 1'b1, 48'd0, 1'b0);
    add_row('0, 1'b1, 1'b1, ENERGY_MAX, 1'b1);
    add_row('1, 1'b1, 1'b1, ENERGY_MAX, 1'b1);
    add_row('1, 1'b0, 1'b1, 48'd0, 1'b0);
    add_row(ident, 1'b1, 1'b0, 48'd0, 1'b0);
    f = ident; f.area = 32'hFFFF_FFFF; add_row(f, 1'b1, 1'b0, 48'd0, 1'b0);
    f = ident; f.u1 = 32'h8000_0000; f.u0 = 32'h7FFF_FFFF; add_row(f, 1'b1, 1'b0, 0, 0);
    f = ident; f.u1 = 32'h7FFF_FFFF; f.u0 = 32'h8000_0000; add_row(f, 1'b1, 1'b0, 0, 0);
    f = ident; f.m00 = 32'h7FFF_FFFF; f.m11 = 32'h7FFF_FFFF; add_row(f, 1'b1, 1'b0, 0, 0);
    f = ident; f.m00 = 32'h8000_0000; add_row(f, 1'b1, 1'b1, ENERGY_MAX, 1'b1);
    f = ident; f.v2 = 32'h0000_0001; f.u1 = 32'h0000_0001; add_row(f, 1'b1, 1'b0, 0, 0);
    f = ident; f.m11 = 32'h0000_0100; add_row(f, 1'b1, 1'b0, 0, 0);
    f = ident; f.u2 = 32'h0001_0000; f.v1 = 32'h0001_0000; add_row(f, 1'b1, 1'b1, ENERGY_MAX, 1'b1);
    for (int i = 0; i < rows.size(); i++) begin
      p = '{default: '0};
      send_face(rows[i].f, rows[i].ok);
      if (rows[i].has_exp) begin
        p = last_pred;
        if (p.energy !== rows[i].exp_energy || p.flipped !== rows[i].exp_flip) begin
          errors++;
          $display("ERROR: table row %0d disagrees with prediction", i);
        end
      end
    end
    drain_results();

    // Floor at its top on tiny faces, then pass lengths with saturation.
    write_reg(REG_DET_FLOOR, 65535);
    write_reg(REG_FACE_COUNT, 3);
    for (int i = 0; i < 6; i++) begin
      f = ident; f.u1 = 32'h0000_0100 * (i + 1); f.v2 = 32'h0000_0100;
      send_face(f, 1'b1);
    end
    send_face('1, 1'b1);
    for (int i = 0; i < 4; i++) begin
      f = ident; f.area = 32'hFFFF_FFFF; f.m00 = 32'h7FFF_FFFF; f.m11 = 32'h0000_0002;
      send_face(f, 1'b1);
    end
    drain_results();

    // Random part over several settings; one long receiver hold-off.
    lens = '{0, 1, 7, 131071};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_FACE_COUNT, lens[ph]);
      write_reg(REG_DET_FLOOR, (ph == 1) ? 0 : $urandom_range(0, 65535));
      if (ph == 2) hold_long = 1'b1;
      for (int i = 0; i < RANDOM_FACES / 4; i++)
        send_face(rand_face(), ($urandom_range(0, 7) != 0));
      // Shrink the pass length mid-pass to end it early.
      if (ph == 3) begin
        drain_results();
        write_reg(REG_FACE_COUNT, 2);
        send_face(rand_face(), 1'b1);
      end
      drain_results();
    end

    $display("Covered %0d faces, %0d results, %0d flipped, %0d pass ends.",
             faces_sent, results_seen, flips_seen, passes_seen);
    if (errors == 0)
      $display("mips_face_energy_accumulator_tb: done, clean");
    else
      $display("mips_face_energy_accumulator_tb: done, errors");
    $finish;
  end

endmodule
